FILE: hw/rtl/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// shared constants, opcodes, status codes and types of the vector alu
// ----------------------------------------------------------------------------
package v3a_pkg;

    localparam int FX_W      = 32;
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 3;
    localparam int OP_W      = 4;
    localparam int ST_W      = 2;
    localparam int PROD_W    = 2 * FX_W;
    localparam int SQ_W      = PROD_W;
    localparam int RT_W      = SQ_W / 2;
    localparam int Q_W       = FX_W + FRAC_BITS;

    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
    localparam logic [OP_W-1:0] OP_NEG    = 4'd4;
    localparam logic [OP_W-1:0] OP_SCALE  = 4'd5;
    localparam logic [OP_W-1:0] OP_DOT    = 4'd6;
    localparam logic [OP_W-1:0] OP_CROSS  = 4'd7;
    localparam logic [OP_W-1:0] OP_LEN    = 4'd8;
    localparam logic [OP_W-1:0] OP_NORM   = 4'd9;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT = 2'd1;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

    localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

    typedef logic [LANES-1:0][FX_W-1:0] t_vec;
    typedef logic [LANES-1:0][Q_W-1:0]  t_qvec;

    // request fields that ride along the long pipeline
    typedef struct packed {
        logic [OP_W-1:0]  op;
        t_vec             a;
        t_vec             dmag;
        logic [LANES-1:0] neg;
        t_vec             r;
        logic             sat;
        logic             sq_zero;
    } t_side;

endpackage

FILE: hw/rtl/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front
// product stage and rounding/saturation stage
// ----------------------------------------------------------------------------
module v3a_front import v3a_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [OP_W-1:0] i_op,
    input  t_vec            i_a,
    input  t_vec            i_b,
    input  logic [FX_W-1:0] i_s,
    output logic            o_vld,
    output t_side           o_side,
    output logic [SQ_W-1:0] o_sq
);

    localparam int ACC_W = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] LIM_HI   = ACC_W'(FX_MAX);
    localparam logic signed [ACC_W-1:0] LIM_LO   = ACC_W'(FX_MIN);

    typedef struct packed {
        logic [FX_W-1:0] v;
        logic            sat;
    } t_sres;

    function automatic t_sres clamp(input logic signed [ACC_W-1:0] v);
        t_sres res;
        if (v > LIM_HI) begin
            res = '{v: FX_MAX, sat: 1'b1};
        end else if (v < LIM_LO) begin
            res = '{v: FX_MIN, sat: 1'b1};
        end else begin
            res = '{v: v[FX_W-1:0], sat: 1'b0};
        end
        return res;
    endfunction

    function automatic t_sres rnd(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + RND_HALF) >>> FRAC_BITS;
        return clamp(t);
    endfunction

    // stage 1: products
    logic                     r1_vld;
    logic [OP_W-1:0]          r1_op;
    t_vec                     r1_a;
    t_vec                     r1_b;
    logic signed [PROD_W-1:0] r1_p [2*LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
        if (i_en) begin
            r1_op <= i_op;
            r1_a  <= i_a;
            r1_b  <= i_b;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_mul
        localparam int J = (g + 1) % LANES;
        localparam int K = (g + 2) % LANES;
        logic signed [FX_W-1:0] m_x;
        logic signed [FX_W-1:0] m_y;

        always_comb begin
            m_x = $signed(i_a[g]);
            m_y = $signed(i_b[g]);
            unique case (i_op) inside
                OP_SCALE: m_y = $signed(i_s);
                OP_LEN, OP_NORM: m_y = $signed(i_a[g]);
                OP_CROSS: begin
                    m_x = $signed(i_a[J]);
                    m_y = $signed(i_b[K]);
                end
                default: ;
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_p[g]         <= m_x * m_y;
                r1_p[g + LANES] <= $signed(i_a[K]) * $signed(i_b[J]);
            end
        end
    end

    // stage 2: sums, rounding, saturation
    t_side           n_side;
    logic [SQ_W-1:0] n_sq;
    logic            r2_vld;
    t_side           r2_side;
    logic [SQ_W-1:0] r2_sq;

    always_comb begin
        logic signed [ACC_W-1:0] ea;
        logic signed [ACC_W-1:0] eb;
        t_sres                   res;
        n_side     = '0;
        n_side.op  = r1_op;
        n_side.a   = r1_a;
        n_sq       = r1_p[0][SQ_W-1:0] + r1_p[1][SQ_W-1:0] + r1_p[2][SQ_W-1:0];
        n_side.sq_zero = (n_sq == '0);
        for (int i = 0; i < LANES; i++) begin
            ea  = ACC_W'($signed(r1_a[i]));
            eb  = ACC_W'($signed(r1_b[i]));
            res = '0;
            case (r1_op) inside
                OP_ADD:   res = clamp(ea + eb);
                OP_SUB:   res = clamp(ea - eb);
                OP_NEG:   res = clamp(ACC_W'(0) - ea);
                OP_MUL, OP_SCALE: res = rnd(ACC_W'(r1_p[i]));
                OP_DOT: begin
                    if (i == 0) begin
                        res = rnd(ACC_W'(r1_p[0]) + ACC_W'(r1_p[1]) + ACC_W'(r1_p[2]));
                    end
                end
                OP_CROSS: res = rnd(ACC_W'(r1_p[i]) - ACC_W'(r1_p[i + LANES]));
                default: ;
            endcase
            n_side.r[i]    = res.v;
            n_side.sat     = n_side.sat | res.sat;
            n_side.dmag[i] = r1_b[i][FX_W-1] ? FX_W'(~r1_b[i] + 1'b1) : r1_b[i];
            n_side.neg[i]  = (r1_op == OP_DIV) ? (r1_a[i][FX_W-1] ^ r1_b[i][FX_W-1])
                                                : r1_a[i][FX_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r2_side <= n_side;
            r2_sq   <= n_sq;
        end
    end

    assign o_vld  = r2_vld;
    assign o_side = r2_side;
    assign o_sq   = r2_sq;

endmodule

FILE: hw/rtl/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt
// pipelined square root, two radicand bits per stage, rounded to nearest
// ----------------------------------------------------------------------------
module v3a_sqrt import v3a_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_side           i_side,
    input  logic [SQ_W-1:0] i_sq,
    output logic            o_vld,
    output t_side           o_side,
    output logic [RT_W-1:0] o_len
);

    localparam int REM_W = RT_W + 2;

    logic             r_vld  [RT_W];
    t_side            r_side [RT_W];
    logic [SQ_W-1:0]  r_rad  [RT_W];
    logic [RT_W-1:0]  r_root [RT_W];
    logic [REM_W-1:0] r_rem  [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_stage
        logic             vld_in;
        t_side            side_in;
        logic [SQ_W-1:0]  rad_in;
        logic [RT_W-1:0]  root_in;
        logic [REM_W-1:0] rem_in;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign side_in = i_side;
            assign rad_in  = i_sq;
            assign root_in = '0;
            assign rem_in  = '0;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign side_in = r_side[k-1];
            assign rad_in  = r_rad[k-1];
            assign root_in = r_root[k-1];
            assign rem_in  = r_rem[k-1];
        end

        assign cur   = {rem_in, rad_in[SQ_W-1 -: 2]};
        assign trial = (REM_W + 2)'({root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
            if (i_en) begin
                r_side[k] <= side_in;
                r_rad[k]  <= rad_in << 2;
                if (cur >= trial) begin
                    r_rem[k]  <= REM_W'(cur - trial);
                    r_root[k] <= {root_in[RT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= cur[REM_W-1:0];
                    r_root[k] <= {root_in[RT_W-2:0], 1'b0};
                end
            end
        end
    end

    // round: remainder above the root means the true root is past the half
    logic            r_o_vld;
    t_side           r_o_side;
    logic [RT_W-1:0] r_o_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[RT_W-1];
        end
        if (i_en) begin
            r_o_side <= r_side[RT_W-1];
            r_o_len  <= (r_rem[RT_W-1] > REM_W'(r_root[RT_W-1])) ?
                        r_root[RT_W-1] + 1'b1 : r_root[RT_W-1];
        end
    end

    assign o_vld  = r_o_vld;
    assign o_side = r_o_side;
    assign o_len  = r_o_len;

endmodule

FILE: hw/rtl/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module v3a_div import v3a_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_side           i_side,
    input  logic [RT_W-1:0] i_len,
    output logic            o_vld,
    output t_side           o_side,
    output t_qvec           o_q
);

    // operand setup: divisor choice, rounding offset, length result
    logic  r_p_vld;
    t_side r_p_side;
    t_qvec r_p_num;
    t_vec  r_p_den;
    t_side n_p_side;
    t_qvec n_p_num;
    t_vec  n_p_den;

    always_comb begin
        logic [FX_W-1:0] amag;
        n_p_side = i_side;
        if (i_side.op == OP_LEN) begin
            n_p_side.r[0] = i_len[RT_W-1] ? FX_MAX : FX_W'(i_len);
            n_p_side.sat  = i_len[RT_W-1];
        end
        for (int l = 0; l < LANES; l++) begin
            amag       = i_side.a[l][FX_W-1] ? FX_W'(~i_side.a[l] + 1'b1) : i_side.a[l];
            n_p_den[l] = (i_side.op == OP_NORM) ? FX_W'(i_len) : i_side.dmag[l];
            n_p_num[l] = {amag, {FRAC_BITS{1'b0}}} + Q_W'(n_p_den[l] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_vld;
        end
        if (i_en) begin
            r_p_side <= n_p_side;
            r_p_num  <= n_p_num;
            r_p_den  <= n_p_den;
        end
    end

    logic  r_vld  [Q_W];
    t_side r_side [Q_W];
    t_vec  r_den  [Q_W];
    t_vec  r_rem  [Q_W];
    t_qvec r_nq   [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic                       vld_in;
        t_side                      side_in;
        t_vec                       den_in;
        t_vec                       rem_in;
        t_qvec                      nq_in;
        logic [LANES-1:0][FX_W:0]   cur;
        logic [LANES-1:0]           ge;
        t_vec                       n_rem;
        t_qvec                      n_nq;

        if (k == 0) begin : g_first
            assign vld_in  = r_p_vld;
            assign side_in = r_p_side;
            assign den_in  = r_p_den;
            assign rem_in  = '0;
            assign nq_in   = r_p_num;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign side_in = r_side[k-1];
            assign den_in  = r_den[k-1];
            assign rem_in  = r_rem[k-1];
            assign nq_in   = r_nq[k-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                cur[l]   = {rem_in[l], nq_in[l][Q_W-1]};
                ge[l]    = cur[l] >= {1'b0, den_in[l]};
                n_rem[l] = ge[l] ? FX_W'(cur[l] - {1'b0, den_in[l]}) : cur[l][FX_W-1:0];
                n_nq[l]  = {nq_in[l][Q_W-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
            if (i_en) begin
                r_side[k] <= side_in;
                r_den[k]  <= den_in;
                r_rem[k]  <= n_rem;
                r_nq[k]   <= n_nq;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];
    assign o_q    = r_nq[Q_W-1];

endmodule

FILE: hw/rtl/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// three-component signed fixed-point vector alu, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_opcode, i_a_*, i_b_*, i_scale_factor
//  result    out        o_valid / i_stall   o_r_x, o_r_y, o_r_z, o_status
//
//  one request enters per cycle while o_stall is low; data is Q16.16, and
//  each request passes the 32-stage square root and the 48-stage divider
//  every opcode runs the full pipe so results leave in request order
//  a held result freezes the whole pipe; o_stall follows i_stall only then
//  synchronous active-low reset clears the valid bits only
//
module vector3_alu import v3a_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [OP_W-1:0] i_opcode,
    input  logic [FX_W-1:0] i_a_x,
    input  logic [FX_W-1:0] i_a_y,
    input  logic [FX_W-1:0] i_a_z,
    input  logic [FX_W-1:0] i_b_x,
    input  logic [FX_W-1:0] i_b_y,
    input  logic [FX_W-1:0] i_b_z,
    input  logic [FX_W-1:0] i_scale_factor,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [FX_W-1:0] o_r_x,
    output logic [FX_W-1:0] o_r_y,
    output logic [FX_W-1:0] o_r_z,
    output logic [ST_W-1:0] o_status
);

    localparam logic [Q_W-1:0] QLIM_POS = Q_W'(FX_MAX);
    localparam logic [Q_W-1:0] QLIM_NEG = Q_W'(1) << (FX_W - 1);

    // global advance: pipe moves unless a finished result is being held
    logic en;
    logic r_out_vld;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // front: products, then sums with rounding and saturation
    logic            f_vld;
    t_side           f_side;
    logic [SQ_W-1:0] f_sq;

    v3a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_op    (i_opcode),
        .i_a     ({i_a_z, i_a_y, i_a_x}),
        .i_b     ({i_b_z, i_b_y, i_b_x}),
        .i_s     (i_scale_factor),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_sq    (f_sq)
    );

    // length of a from the sum of squares
    logic            s_vld;
    t_side           s_side;
    logic [RT_W-1:0] s_len;

    v3a_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_sq    (f_sq),
        .o_vld   (s_vld),
        .o_side  (s_side),
        .o_len   (s_len)
    );

    // elementwise divide or divide by length
    logic  d_vld;
    t_side d_side;
    t_qvec d_q;

    v3a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_side  (s_side),
        .i_len   (s_len),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_q     (d_q)
    );

    // finish: quotient sign and saturation, zero divisor, zero-length normalize
    t_vec            n_r;
    logic [ST_W-1:0] n_st;

    always_comb begin
        logic sat;
        logic dz;
        logic qsat;
        logic [FX_W-1:0] qv;
        sat = d_side.sat;
        dz  = 1'b0;
        n_r = d_side.r;
        for (int l = 0; l < LANES; l++) begin
            // signed quotient with clamping
            qsat = 1'b0;
            if (!d_side.neg[l]) begin
                qsat = d_q[l] > QLIM_POS;
                qv   = qsat ? FX_MAX : d_q[l][FX_W-1:0];
            end else begin
                qsat = d_q[l] > QLIM_NEG;
                qv   = qsat ? FX_MIN : FX_W'(~d_q[l][FX_W-1:0] + 1'b1);
            end
            case (d_side.op) inside
                OP_DIV: begin
                    if (d_side.dmag[l] == '0) begin
                        dz = 1'b1;
                        if (d_side.a[l][FX_W-1]) begin
                            n_r[l] = FX_MIN;
                        end else if (d_side.a[l] != '0) begin
                            n_r[l] = FX_MAX;
                        end else begin
                            n_r[l] = '0;
                        end
                    end else begin
                        n_r[l] = qv;
                        sat    = sat | qsat;
                    end
                end
                OP_NORM: begin
                    if (d_side.sq_zero) begin
                        n_r[l] = d_side.a[l];
                    end else begin
                        n_r[l] = qv;
                        sat    = sat | qsat;
                    end
                end
                default: ;
            endcase
        end
        n_st = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
    end

    // output register
    t_vec            r_out_r;
    logic [ST_W-1:0] r_out_st;
    logic [OP_W-1:0] r_out_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
        if (en) begin
            r_out_r  <= n_r;
            r_out_st <= n_st;
            r_out_op <= d_side.op;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_r_x    = r_out_r[0];
    assign o_r_y    = r_out_r[1];
    assign o_r_z    = r_out_r[2];
    assign o_status = r_out_st;

    // scalar results leave y and z clear
    a_scalar_yz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_op == OP_DOT || r_out_op == OP_LEN)
        |-> o_r_y == '0 && o_r_z == '0)
        else $error("scalar result with nonzero y or z");

    // only the divide opcode can report a zero divisor
    a_dz_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && o_status == ST_DZ |-> r_out_op == OP_DIV)
        else $error("zero-divisor status on a non-divide result");

    // undefined opcodes give a clear result
    a_undef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_op > OP_NORM
        |-> o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && o_status == ST_OK)
        else $error("undefined opcode gave a nonzero result");

    // status code three is never produced
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> o_status != 2'd3)
        else $error("unused status code on output");

endmodule

FILE: verif/vector3_alu_chk.sv
// ----------------------------------------------------------------------------
// vector3_alu_chk
// watches both channels, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module vector3_alu_chk import v3a_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall_req,
    input  logic [OP_W-1:0] i_opcode,
    input  logic [FX_W-1:0] i_a_x,
    input  logic [FX_W-1:0] i_a_y,
    input  logic [FX_W-1:0] i_a_z,
    input  logic [FX_W-1:0] i_b_x,
    input  logic [FX_W-1:0] i_b_y,
    input  logic [FX_W-1:0] i_b_z,
    input  logic [FX_W-1:0] i_scale_factor,
    input  logic            i_res_valid,
    input  logic            i_res_stall,
    input  logic [FX_W-1:0] i_r_x,
    input  logic [FX_W-1:0] i_r_y,
    input  logic [FX_W-1:0] i_r_z,
    input  logic [ST_W-1:0] i_status,
    output int              o_fail_cnt,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [65:0] t_wide;

    typedef struct {
        logic [FX_W-1:0] x;
        logic [FX_W-1:0] y;
        logic [FX_W-1:0] z;
        logic [ST_W-1:0] st;
    } t_vec_res;

    t_vec_res result_fifo[$];
    int       fail_cnt = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = result_fifo.size();

    function automatic logic [FX_W-1:0] clamp_fx(input t_wide v, inout logic sat);
        if (v > t_wide'(FX_MAX)) begin
            sat = 1'b1;
            return FX_MAX;
        end
        if (v < t_wide'(FX_MIN)) begin
            sat = 1'b1;
            return FX_MIN;
        end
        return v[FX_W-1:0];
    endfunction

    // round half up at the binary point, then saturate
    function automatic logic [FX_W-1:0] round_fx(input t_wide acc, inout logic sat);
        t_wide t;
        t = (acc + t_wide'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return clamp_fx(t, sat);
    endfunction

    function automatic logic [FX_W-1:0] div_mag(input logic signed [FX_W-1:0] num,
                                                input logic [63:0] den, input logic neg,
                                                inout logic sat);
        logic [63:0] m;
        logic [63:0] q;
        t_wide       v;
        m = num < 0 ? 64'(-t_wide'(num)) : 64'(num);
        q = ((m << FRAC_BITS) + den / 2) / den;
        v = neg ? -t_wide'({2'b0, q}) : t_wide'({2'b0, q});
        return clamp_fx(v, sat);
    endfunction

    function automatic logic [63:0] isqrt_near(input logic [63:0] n);
        logic [63:0] res, bitv, rem;
        res = 0;
        bitv = 64'd1 << 62;
        rem = n;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return rem > res ? res + 1 : res;
    endfunction

    function automatic t_vec_res predict_vec(input logic [OP_W-1:0] op,
                                             input logic [2:0][FX_W-1:0] av,
                                             input logic [2:0][FX_W-1:0] bv,
                                             input logic [FX_W-1:0] sf);
        t_vec_res          res;
        logic              sat, dz;
        logic signed [FX_W-1:0] a [3];
        logic signed [FX_W-1:0] b [3];
        logic [FX_W-1:0]   r [3];
        t_wide             s, acc;
        logic [63:0]       sq, len;
        int                j, k;
        sat = 1'b0;
        dz = 1'b0;
        s = t_wide'($signed(sf));
        for (int i = 0; i < 3; i++) begin
            a[i] = av[i];
            b[i] = bv[i];
            r[i] = '0;
        end
        case (op)
            OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp_fx(t_wide'(a[i]) + b[i], sat);
            OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp_fx(t_wide'(a[i]) - b[i], sat);
            OP_MUL: for (int i = 0; i < 3; i++)
                r[i] = round_fx(t_wide'(a[i]) * t_wide'(b[i]), sat);
            OP_DIV: for (int i = 0; i < 3; i++) begin
                if (b[i] == 0) begin
                    dz = 1'b1;
                    r[i] = a[i] > 0 ? FX_MAX : (a[i] < 0 ? FX_MIN : '0);
                end else begin
                    r[i] = div_mag(a[i], b[i] < 0 ? 64'(-t_wide'(b[i])) : 64'(b[i]),
                                   (a[i] < 0) != (b[i] < 0), sat);
                end
            end
            OP_NEG: for (int i = 0; i < 3; i++) r[i] = clamp_fx(-t_wide'(a[i]), sat);
            OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_fx(t_wide'(a[i]) * s, sat);
            OP_DOT: begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += t_wide'(a[i]) * t_wide'(b[i]);
                r[0] = round_fx(acc, sat);
            end
            OP_CROSS: for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                acc = t_wide'(a[j]) * t_wide'(b[k]) - t_wide'(a[k]) * t_wide'(b[j]);
                r[i] = round_fx(acc, sat);
            end
            OP_LEN, OP_NORM: begin
                sq = 0;
                for (int i = 0; i < 3; i++) sq += 64'(t_wide'(a[i]) * t_wide'(a[i]));
                len = isqrt_near(sq);
                if (op == OP_LEN) begin
                    if (len > 64'(2147483647)) begin
                        sat = 1'b1;
                        r[0] = FX_MAX;
                    end else begin
                        r[0] = len[FX_W-1:0];
                    end
                end else if (sq == 0) begin
                    for (int i = 0; i < 3; i++) r[i] = a[i];
                end else begin
                    for (int i = 0; i < 3; i++) r[i] = div_mag(a[i], len, a[i] < 0, sat);
                end
            end
            default: ;
        endcase
        res.x = r[0];
        res.y = r[1];
        res.z = r[2];
        res.st = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_vec_res want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_req)
                result_fifo.push_back(predict_vec(i_opcode, {i_a_z, i_a_y, i_a_x},
                                                  {i_b_z, i_b_y, i_b_x}, i_scale_factor));
            if (i_res_valid && !i_res_stall) begin
                if (result_fifo.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%t unexpected result %h %h %h st %0d", $realtime,
                                 i_r_x, i_r_y, i_r_z, i_status);
                end else begin
                    want = result_fifo.pop_front();
                    if (want.x !== i_r_x || want.y !== i_r_y || want.z !== i_r_z ||
                        want.st !== i_status) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("%t mismatch exp %h %h %h st %0d got %h %h %h st %0d",
                                     $realtime, want.x, want.y, want.z, want.st,
                                     i_r_x, i_r_y, i_r_z, i_status);
                    end
                end
            end
        end
    end

endmodule

FILE: verif/vector3_alu_tb.sv
// ----------------------------------------------------------------------------
// vector3_alu_tb
// directed corner requests then random ones under three idle patterns,
// results checked against a predictor in the checker module
// ----------------------------------------------------------------------------
module vector3_alu_tb import v3a_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [OP_W-1:0] i_opcode;
    logic [FX_W-1:0] i_a_x, i_a_y, i_a_z;
    logic [FX_W-1:0] i_b_x, i_b_y, i_b_z;
    logic [FX_W-1:0] i_scale_factor;
    logic            o_valid;
    logic            i_stall;
    logic [FX_W-1:0] o_r_x, o_r_y, o_r_z;
    logic [ST_W-1:0] o_status;
    int              fail_cnt;
    int              pending;
    int              tx_idle_pct;
    int              rx_idle_pct;

    localparam logic [FX_W-1:0] FX_ONE_W = 32'h0001_0000;
    localparam logic [FX_W-1:0] FX_M1_W  = 32'hFFFF_0000;

    vector3_alu u_dut (.*);

    vector3_alu_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_req(o_stall),
        .i_opcode(i_opcode), .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z), .i_scale_factor(i_scale_factor),
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_r_x(o_r_x), .i_r_y(o_r_y),
        .i_r_z(o_r_z), .i_status(o_status), .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) i_stall <= ($urandom_range(99) < rx_idle_pct);

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // one request: optional idle cycles, then hold it until accepted
    task automatic send_req(input logic [OP_W-1:0] op, input logic [FX_W-1:0] ax,
                            input logic [FX_W-1:0] ay, input logic [FX_W-1:0] az,
                            input logic [FX_W-1:0] bx, input logic [FX_W-1:0] by,
                            input logic [FX_W-1:0] bz, input logic [FX_W-1:0] sf);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_a_x          <= ax;
        i_a_y          <= ay;
        i_a_z          <= az;
        i_b_x          <= bx;
        i_b_y          <= by;
        i_b_z          <= bz;
        i_scale_factor <= sf;
        // stall is settled by the falling edge
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
    endtask

    // operand mix: small values, full range, landmarks and mid range
    function automatic logic [FX_W-1:0] rand_fx();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return FX_W'($signed($urandom_range(1 << 19)) - (1 << 18));
        if (pick < 70) return $urandom();
        if (pick < 85) begin
            case ($urandom_range(6))
                0: return '0;
                1: return FX_ONE_W;
                2: return FX_M1_W;
                3: return FX_MAX;
                4: return FX_MIN;
                5: return 32'd1;
                default: return '1;
            endcase
        end
        return FX_W'($signed($urandom_range(1 << 25)) - (1 << 24));
    endfunction

    task automatic send_random();
        logic [OP_W-1:0] op;
        logic [FX_W-1:0] ax, ay, az;
        op = ($urandom_range(99) < 95) ? OP_W'($urandom_range(9)) : OP_W'($urandom_range(15));
        ax = rand_fx();
        ay = rand_fx();
        az = rand_fx();
        // zero vectors for length and normalize now and then
        if ((op == OP_LEN || op == OP_NORM) && $urandom_range(19) == 0) begin
            ax = '0;
            ay = '0;
            az = '0;
        end
        send_req(op, ax, ay, az, rand_fx(), rand_fx(), rand_fx(), rand_fx());
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_opcode       <= OP_ADD;
        i_a_x          <= '0;
        i_a_y          <= '0;
        i_a_z          <= '0;
        i_b_x          <= '0;
        i_b_y          <= '0;
        i_b_z          <= '0;
        i_scale_factor <= '0;
        tx_idle_pct = 33;
        rx_idle_pct = 76;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: every opcode, overflow, zero divisors, zero length
        send_req(OP_ADD, FX_MAX, FX_MIN, FX_ONE_W, 32'd1, FX_M1_W, FX_M1_W, '0);
        send_req(OP_SUB, FX_MIN, FX_MAX, '0, 32'd1, FX_M1_W, FX_MIN, '0);
        send_req(OP_MUL, FX_MAX, FX_MIN, FX_MIN, FX_MAX, FX_MIN, 32'h8000, '0);
        send_req(OP_MUL, 32'h0000_8000, '1, 32'h0001_8000, 32'd1, 32'h8000, FX_M1_W, '0);
        send_req(OP_DIV, FX_ONE_W, FX_M1_W, '0, '0, '0, '0, '0);
        send_req(OP_DIV, FX_MAX, FX_MIN, 32'd3, 32'd1, FX_M1_W, 32'd2, '0);
        send_req(OP_DIV, FX_ONE_W, FX_MAX, '0, '0, 32'd1, FX_M1_W, '0);
        send_req(OP_NEG, FX_MIN, FX_MAX, '0, '0, '0, '0, '0);
        send_req(OP_SCALE, FX_MAX, FX_MIN, 32'd1, '0, '0, '0, FX_MIN);
        send_req(OP_SCALE, FX_ONE_W, FX_M1_W, 32'h1234, '0, '0, '0, 32'h0000_8000);
        send_req(OP_DOT, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, '0);
        send_req(OP_DOT, FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, '0);
        send_req(OP_CROSS, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, '0);
        send_req(OP_CROSS, FX_ONE_W, '0, '0, '0, FX_ONE_W, '0, '0);
        send_req(OP_LEN, FX_MIN, FX_MIN, FX_MIN, '0, '0, '0, '0);
        send_req(OP_LEN, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0);
        send_req(OP_LEN, '0, '0, '0, '0, '0, '0, '0);
        send_req(OP_NORM, '0, '0, '0, FX_MAX, '0, '0, '0);
        send_req(OP_NORM, 32'd1, '0, '0, '0, '0, '0, '0);
        send_req(OP_NORM, FX_MIN, FX_MAX, 32'd5, '0, '0, '0, '0);
        send_req(OP_NORM, 32'h0003_0000, FX_M1_W, 32'h0004_0000, '0, '0, '0, '0);
        send_req(OP_W'(10), FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
        send_req(OP_W'(15), '1, '1, '1, '1, '1, '1, '1);

        // random requests under the three idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 76 : 0;
            rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < 600; n++) send_random();
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
